### rtl/gelu_pkg.sv
// Shared constants and types for the tanh-form GELU datapath.
package gelu_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 12;

  localparam int CUBE_COEF_Q20     = 46887;     // 0.044715
  localparam int TWO_SQRT_2_PI_Q20 = 1673285;   // 2*sqrt(2/pi)
  localparam int LOG2E_Q16         = 94548;
  localparam int LN2_Q24           = 11629080;

  // Reciprocals for exact floor division of values below 2^24, shift 26.
  localparam int RECIP5 = 13421773;
  localparam int RECIP3 = 22369622;

  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  localparam int ARG_STAGES = 7;
  localparam int EXP_STAGES = 7;
  localparam int DIV_STAGES = 13;
  localparam int SIG_WIDTH  = 13;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

endpackage

### rtl/gelu_if.sv
// Valid/ready stream interfaces for the GELU sample and result channels.
interface gelu_in_if #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x;

  modport source (output valid, output x, input ready);
  modport sink (input valid, input x, output ready);
endinterface

interface gelu_out_if #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y;

  modport source (output valid, output y, input ready);
  modport sink (input valid, input y, output ready);
endinterface

### rtl/gelu_tanh_activation.sv
// Top level: GELU (tanh form) on Q4.12 samples, fully pipelined stream datapath.
//
//   channel   dir   beat payload      handshake
//   in_ch     in    x  (signed Q4.12) valid/ready
//   out_ch    out   y  (signed Q4.12) valid/ready
//
// One sample per cycle while the output is not stalled; 7 argument, 7 polynomial,
// 13 divider and 2 output stages, one quotient bit per divider stage.
// Synchronous active-low reset clears only the stage control bits (valid and neg).
// All stages advance together when the output register is empty or taken;
// a stall freezes every stage, nothing is dropped or repeated.
module gelu_tanh_activation #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gelu_in_if.sink    in_ch,
  gelu_out_if.source out_ch
);

  localparam int QW = gelu_pkg::SIG_WIDTH;
  localparam int FB = gelu_pkg::FRAC_BITS;
  localparam int PW = DATA_WIDTH + QW;

  logic adv;

  gelu_pkg::ctl_t        a_ctl, e_ctl, d_ctl;
  logic [DATA_WIDTH-1:0] a_xm, e_xm, d_xm;
  logic [6:0]            a_n;
  logic [23:0]           a_w;
  logic [25:0]           e_d;
  logic [QW-1:0]         d_q;

  logic [QW-1:0]         s;
  logic [PW-1:0]         prod_nxt, rnd;
  logic [DATA_WIDTH-1:0] ym;

  gelu_pkg::ctl_t        f_ctl_r;
  logic [PW-1:0]         prod_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_y_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  gelu_arg #(.DATA_WIDTH(DATA_WIDTH)) u_arg (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_ch.valid),
    .x_i     (in_ch.x),
    .ctl_o   (a_ctl),
    .xm_o    (a_xm),
    .n_o     (a_n),
    .w_o     (a_w)
  );

  gelu_exp #(.DATA_WIDTH(DATA_WIDTH)) u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (a_ctl),
    .xm_i  (a_xm),
    .n_i   (a_n),
    .w_i   (a_w),
    .ctl_o (e_ctl),
    .xm_o  (e_xm),
    .d_o   (e_d)
  );

  gelu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (e_ctl),
    .xm_i  (e_xm),
    .d_i   (e_d),
    .ctl_o (d_ctl),
    .xm_o  (d_xm),
    .q_o   (d_q)
  );

  // negative u: logistic term is one minus sig
  assign s        = d_ctl.neg ? QW'(13'd4096 - d_q) : d_q;
  assign prod_nxt = PW'(d_xm) * PW'(s);
  assign rnd      = prod_r + (PW'(1) << (FB - 1));
  assign ym       = rnd[DATA_WIDTH+FB-1:FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ctl_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      f_ctl_r     <= d_ctl;
      out_valid_r <= f_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      out_y_r <= f_ctl_r.neg ? DATA_WIDTH'(-ym) : ym;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.y     = out_y_r;

endmodule

### rtl/gelu_arg.sv
// Argument stages: clamp, cubic term, u = 2*sqrt(2/pi)*a, split into 2^-n and exp fraction.
module gelu_arg #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  output gelu_pkg::ctl_t               ctl_o,
  output logic        [DATA_WIDTH-1:0] xm_o,
  output logic        [6:0]            n_o,
  output logic        [23:0]           w_o
);

  localparam int NS = gelu_pkg::ARG_STAGES;

  gelu_pkg::ctl_t        ctl_r [NS];
  logic [DATA_WIDTH-1:0] xm_r  [NS];

  logic signed [31:0] x32;
  logic signed [16:0] xc;
  logic [16:0]        m_nxt;
  logic [DATA_WIDTH-1:0] xm_nxt;

  logic [16:0] m_r, m2d_r, m3d_r;
  logic [33:0] sq;
  logic [32:0] mc;
  logic [30:0] m2_r, mc_r;
  logic [61:0] cube;
  logic [60:0] p_r;
  logic [60:0] t_sum;
  logic [17:0] a_sum;
  logic [16:0] am_r;
  logic [37:0] u_sum;
  logic [17:0] um_r;
  logic [34:0] v;
  logic [6:0]  n6_r, n_r;
  logic [27:0] frac_r;
  logic [51:0] wp;
  logic [23:0] w_r;

  // S1: clamp for the logistic path, magnitudes
  always_comb begin
    x32 = 32'(x_i);
    if (x32 > 32'sd32767) begin
      xc = 17'sd32767;
    end else if (x32 < -32'sd32768) begin
      xc = -17'sd32768;
    end else begin
      xc = x32[16:0];
    end
    m_nxt  = xc[16] ? 17'(-xc) : 17'(xc);
    xm_nxt = x_i[DATA_WIDTH-1] ? DATA_WIDTH'(-x_i) : DATA_WIDTH'(x_i);
  end

  // S2..S7 datapath
  assign sq    = 34'(m_r) * 34'(m_r);
  assign mc    = 33'(m_r) * 33'(gelu_pkg::CUBE_COEF_Q20);
  assign cube  = 62'(m2_r) * 62'(mc_r);
  assign t_sum = p_r + (61'(1) << 43);
  assign a_sum = 18'(m3d_r) + 18'(t_sum[60:44]);
  assign u_sum = 38'(am_r) * 38'(gelu_pkg::TWO_SQRT_2_PI_Q20) + (38'(1) << 19);
  assign v     = 35'(um_r) * 35'(gelu_pkg::LOG2E_Q16);
  assign wp    = 52'(frac_r) * 52'(gelu_pkg::LN2_Q24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= '{valid: valid_i, neg: x_i[DATA_WIDTH-1]};
      for (int k = 1; k < NS; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xm_r[0] <= xm_nxt;
      for (int k = 1; k < NS; k++) begin
        xm_r[k] <= xm_r[k-1];
      end
      m_r    <= m_nxt;
      m2_r   <= sq[30:0];
      mc_r   <= mc[30:0];
      m2d_r  <= m_r;
      p_r    <= cube[60:0];
      m3d_r  <= m2d_r;
      am_r   <= a_sum[16:0];
      um_r   <= u_sum[37:20];
      n6_r   <= v[34:28];
      frac_r <= v[27:0];
      n_r    <= n6_r;
      w_r    <= wp[51:28];
    end
  end

  assign ctl_o = ctl_r[NS-1];
  assign xm_o  = xm_r[NS-1];
  assign n_o   = n_r;
  assign w_o   = w_r;

endmodule

### rtl/gelu_exp.sv
// Horner polynomial for exp(-w), power-of-two scaling, divisor 1 + exp(-|u|) in Q.24.
module gelu_exp #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  gelu_pkg::ctl_t        ctl_i,
  input  logic [DATA_WIDTH-1:0] xm_i,
  input  logic [6:0]            n_i,
  input  logic [23:0]           w_i,
  output gelu_pkg::ctl_t        ctl_o,
  output logic [DATA_WIDTH-1:0] xm_o,
  output logic [25:0]           d_o
);

  localparam int NS = gelu_pkg::EXP_STAGES;
  localparam logic [24:0] ONE = gelu_pkg::ONE_Q24;

  gelu_pkg::ctl_t        ctl_r [NS];
  logic [DATA_WIDTH-1:0] xm_r  [NS];
  logic [23:0]           w_r   [NS-2];
  logic [6:0]            n_r   [NS-1];

  logic [47:0] q5p;
  logic [48:0] h2, h3, q3p, h5, h6;
  logic [24:0] p1_r, p2, p3_r, p4, p5, e;
  logic [23:0] r1_r, r2_r, r3_r, r4_r;
  logic [25:0] d_r;

  assign q5p = 48'(w_i) * 48'(gelu_pkg::RECIP5);
  assign h2  = 49'(w_r[0]) * 49'(p1_r);
  assign p2  = ONE - 25'(r1_r >> 2);
  assign h3  = 49'(w_r[1]) * 49'(p2);
  assign q3p = 49'(r2_r) * 49'(gelu_pkg::RECIP3);
  assign h5  = 49'(w_r[3]) * 49'(p3_r);
  assign p4  = ONE - 25'(r3_r >> 1);
  assign h6  = 49'(w_r[4]) * 49'(p4);
  assign p5  = ONE - 25'(r4_r);
  assign e   = p5 >> n_r[NS-2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < NS; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xm_r[0] <= xm_i;
      for (int k = 1; k < NS; k++) begin
        xm_r[k] <= xm_r[k-1];
      end
      w_r[0] <= w_i;
      for (int k = 1; k < NS - 2; k++) begin
        w_r[k] <= w_r[k-1];
      end
      n_r[0] <= n_i;
      for (int k = 1; k < NS - 1; k++) begin
        n_r[k] <= n_r[k-1];
      end
      p1_r <= ONE - 25'(q5p[47:26]);
      r1_r <= h2[47:24];
      r2_r <= h3[47:24];
      p3_r <= ONE - 25'(q3p[48:26]);
      r3_r <= h5[47:24];
      r4_r <= h6[47:24];
      d_r  <= 26'(ONE) + 26'(e);
    end
  end

  assign ctl_o = ctl_r[NS-1];
  assign xm_o  = xm_r[NS-1];
  assign d_o   = d_r;

endmodule

### rtl/gelu_div.sv
// Pipelined restoring divider: sig = round(2^36 / d), one quotient bit per stage.
module gelu_div #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  gelu_pkg::ctl_t                     ctl_i,
  input  logic [DATA_WIDTH-1:0]              xm_i,
  input  logic [25:0]                        d_i,
  output gelu_pkg::ctl_t                     ctl_o,
  output logic [DATA_WIDTH-1:0]              xm_o,
  output logic [gelu_pkg::SIG_WIDTH-1:0]     q_o
);

  localparam int NS = gelu_pkg::DIV_STAGES;
  localparam int QW = gelu_pkg::SIG_WIDTH;

  gelu_pkg::ctl_t        ctl_r [NS];
  logic [DATA_WIDTH-1:0] xm_r  [NS];
  logic [QW-1:0]         q_r   [NS];
  logic [37:0]           rem_r [NS-1];
  logic [25:0]           d_r   [NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    gelu_pkg::ctl_t        c_in;
    logic [DATA_WIDTH-1:0] xm_in;
    logic [QW-1:0]         q_in;
    logic [37:0]           rem_in;
    logic [25:0]           d_in;
    logic [38:0]           diff;
    logic                  ge;
    logic [QW-1:0]         q_nxt;
    logic [37:0]           rem_nxt;

    if (j == 0) begin : g_first
      // dividend 2^36 + d/2 gives round to nearest
      assign c_in   = ctl_i;
      assign xm_in  = xm_i;
      assign q_in   = '0;
      assign rem_in = (38'(1) << 36) + 38'(d_i[25:1]);
      assign d_in   = d_i;
    end else begin : g_next
      assign c_in   = ctl_r[j-1];
      assign xm_in  = xm_r[j-1];
      assign q_in   = q_r[j-1];
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
    end

    assign diff = {1'b0, rem_in} - (39'(d_in) << (NS - 1 - j));
    assign ge   = !diff[38];

    always_comb begin
      q_nxt             = q_in;
      q_nxt[NS - 1 - j] = ge;
      rem_nxt           = ge ? diff[37:0] : rem_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (adv) begin
        ctl_r[j] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        xm_r[j] <= xm_in;
        q_r[j]  <= q_nxt;
      end
    end

    if (j < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j] <= rem_nxt;
          d_r[j]   <= d_in;
        end
      end
    end else begin : g_last
      logic unused_rem;
      assign unused_rem = ^rem_nxt;
    end
  end

  assign ctl_o = ctl_r[NS-1];
  assign xm_o  = xm_r[NS-1];
  assign q_o   = q_r[NS-1];

endmodule

### bench/gelu_tanh_activation_test.sv
// Self-checking bench for the tanh-form GELU stream block: fixed-point predictor, random stalls.
module gelu_tanh_activation_test;

  localparam int  RANDOM_SAMPLES = 800;
  localparam int  DRAIN_CYCLES   = 40;
  localparam int  CYCLE_LIMIT    = 200000;
  localparam int  MAX_REPORTS    = 10;

  localparam longint          CUBE_Q20     = 46887;
  localparam longint          TWO_SQRT2_PI = 1673285;
  localparam longint unsigned LOG2E_Q16    = 94548;
  localparam longint unsigned LN2_Q24      = 11629080;
  localparam longint unsigned UNIT_Q24     = 64'd1 << 24;

  typedef struct packed {
    logic signed [15:0] x;
    logic               typed;
    logic signed [15:0] y;
  } sample_t;

  localparam sample_t DIRECTED [0:24] = '{
    '{16'sd0,      1'b1, 16'sd0},
    '{16'sd32767,  1'b1, 16'sd32767},
    '{-16'sd32768, 1'b1, 16'sd0},
    '{16'sd24576,  1'b1, 16'sd24576},
    '{-16'sd24576, 1'b1, 16'sd0},
    '{16'sd1,      1'b0, 16'sd0},
    '{-16'sd1,     1'b0, 16'sd0},
    '{16'sd2,      1'b0, 16'sd0},
    '{-16'sd2,     1'b0, 16'sd0},
    '{16'sd3,      1'b0, 16'sd0},
    '{-16'sd4,     1'b0, 16'sd0},
    '{16'sd2048,   1'b0, 16'sd0},
    '{-16'sd2048,  1'b0, 16'sd0},
    '{16'sd4096,   1'b0, 16'sd0},
    '{-16'sd4096,  1'b0, 16'sd0},
    '{16'sd8192,   1'b0, 16'sd0},
    '{-16'sd8192,  1'b0, 16'sd0},
    '{16'sd16384,  1'b0, 16'sd0},
    '{-16'sd16384, 1'b0, 16'sd0},
    '{16'sd20890,  1'b0, 16'sd0},
    '{-16'sd20890, 1'b0, 16'sd0},
    '{-16'sd31190, 1'b0, 16'sd0},
    '{-16'sd31200, 1'b0, 16'sd0},
    '{16'sd21845,  1'b0, 16'sd0},
    '{-16'sd21846, 1'b0, 16'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  gelu_in_if  in_ch ();
  gelu_out_if out_ch ();

  gelu_tanh_activation dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  sample_t stim[$];
  sample_t gelu_expected[$];
  sample_t head;
  sample_t sent_row;
  int      sent = 0;
  int      mismatches = 0;
  int      cycles = 0;

  function automatic longint round_away(input longint v, input int sh);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // logistic of a nonnegative Q.12 argument, result in Q.12
  function automatic longint unsigned logistic_q12(input longint unsigned mag);
    longint unsigned v, n, frac, w, p, e, den;
    v    = mag * LOG2E_Q16;
    n    = v >> 28;
    frac = v & ((64'd1 << 28) - 64'd1);
    w    = (frac * LN2_Q24) >> 28;
    p    = UNIT_Q24 - w / 5;
    p    = UNIT_Q24 - ((w * p) >> 24) / 4;
    p    = UNIT_Q24 - ((w * p) >> 24) / 3;
    p    = UNIT_Q24 - ((w * p) >> 24) / 2;
    p    = UNIT_Q24 - ((w * p) >> 24);
    e    = (n >= 63) ? 64'd0 : (p >> n);
    den  = UNIT_Q24 + e;
    return ((64'd1 << 36) + (den >> 1)) / den;
  endfunction

  function automatic logic signed [15:0] gelu_q12(input logic signed [15:0] x);
    longint          xs, a, u, y;
    longint unsigned s;
    xs = x;
    a  = xs + round_away(xs * xs * xs * CUBE_Q20, 44);
    u  = round_away(a * TWO_SQRT2_PI, 20);
    if (u < 0) begin
      s = 64'd4096 - logistic_q12(-u);
    end else begin
      s = logistic_q12(u);
    end
    y = round_away(xs * longint'(s), 12);
    return y[15:0];
  endfunction

  // idle percentages per third of the run: receiver idles more, sender idles more, none
  function automatic int send_idle_pct();
    if (sent * 3 < stim.size()) return 25;
    if (sent * 3 < 2 * stim.size()) return 48;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (sent * 3 < stim.size()) return 48;
    if (sent * 3 < 2 * stim.size()) return 25;
    return 0;
  endfunction

  task automatic report(input string what, input sample_t want, input logic [15:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: x=%0d expected y=%0d got y=%0d", what, want.x, want.y, $signed(got));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent_row = stim[sent];
        if (!sent_row.typed) sent_row.y = gelu_q12(sent_row.x);
        gelu_expected.push_back(sent_row);
        sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sent < stim.size() && $urandom_range(0, 99) >= send_idle_pct()) begin
          in_ch.valid <= 1'b1;
          in_ch.x     <= stim[sent].x;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (gelu_expected.size() == 0) begin
          report("unexpected beat", '{16'sd0, 1'b0, 16'sd0}, out_ch.y);
        end else begin
          head = gelu_expected.pop_front();
          if (out_ch.y !== head.y) report("y mismatch", head, out_ch.y);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL gelu_tanh_activation");
      $finish;
    end
  end

  initial begin
    sample_t row;
    int      pick;
    in_ch.valid  = 1'b0;
    in_ch.x      = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;

    foreach (DIRECTED[i]) stim.push_back(DIRECTED[i]);
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      pick = int'($urandom_range(0, 9));
      row.typed = 1'b0;
      row.y     = '0;
      if (pick < 5) begin
        row.x = 16'($urandom());
      end else if (pick < 9) begin
        row.x = 16'(int'($urandom_range(0, 40960)) - 20480);
      end else begin
        row.x = 16'(int'($urandom_range(0, 128)) - 64);
      end
      stim.push_back(row);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (sent < stim.size() || gelu_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS gelu_tanh_activation");
    end else begin
      $display("FAIL gelu_tanh_activation");
    end
    $finish;
  end

endmodule
